// ----- rtl/core/scstu_pkg.sv -----
// Shared widths, reset values and register codes for the soft-threshold update block.
`timescale 1ns / 1ps

package scstu_pkg;

  // Default parameter values.
  localparam int FRAC_BITS_DEF = 12;
  localparam int ACC_WIDTH_DEF = 40;

  // Fixed field widths.
  localparam int VAL_W  = 16;
  localparam int GAIN_W = 16;
  localparam int PROD_W = 32;
  localparam int OUT_W  = 14;

  // The gradient term magnitude is capped at 2^22 raw units.
  localparam int GRAD_CAP_W = 23;
  localparam logic [GRAD_CAP_W-1:0] GRAD_CAP = 23'h400000;

  // Width of the pre-threshold sum prior + grad - decay term.
  localparam int X_W = 26;

  // Configuration register reset values.
  localparam logic [GAIN_W-1:0] STEP_SIZE_RST    = 16'd6554;
  localparam logic [GAIN_W-1:0] HIDDEN_DECAY_RST = 16'd0;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_SIZE    = 1'b0,
    REG_HIDDEN_DECAY = 1'b1
  } cfg_reg_t;

endpackage

// ----- rtl/core/scstu_accum.sv -----
// Input register, error-times-weight product stage and saturating dot accumulator.
`timescale 1ns / 1ps

module scstu_accum #(
  parameter int ACC_WIDTH = scstu_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [scstu_pkg::VAL_W-1:0] error_term,
  input  logic signed [scstu_pkg::VAL_W-1:0] weight,
  input  logic signed [scstu_pkg::VAL_W-1:0] prior_state,
  input  logic [scstu_pkg::VAL_W-1:0]        unit_boost,
  input  logic                              last_term,
  output logic                              sum_valid,
  input  logic                              sum_ready,
  output logic [ACC_WIDTH-1:0]              sum,
  output logic [scstu_pkg::VAL_W-1:0]        sum_prior,
  output logic [scstu_pkg::VAL_W-1:0]        sum_boost
);

  // Input stage.
  logic                               v1;
  logic signed [scstu_pkg::VAL_W-1:0] e1;
  logic signed [scstu_pkg::VAL_W-1:0] w1;
  logic [scstu_pkg::VAL_W-1:0]        prior1;
  logic [scstu_pkg::VAL_W-1:0]        boost1;
  logic                               last1;

  // Product stage.
  logic                                v2;
  logic signed [scstu_pkg::PROD_W-1:0] prod2;
  logic [scstu_pkg::VAL_W-1:0]         prior2;
  logic [scstu_pkg::VAL_W-1:0]         boost2;
  logic                                last2;

  logic [ACC_WIDTH-1:0] acc;

  logic                                rdy1;
  logic                                rdy2;
  logic                                go2;
  logic signed [scstu_pkg::PROD_W-1:0] prod_next;
  logic [ACC_WIDTH:0]                  acc_ext;
  logic [ACC_WIDTH:0]                  prod_ext;
  logic [ACC_WIDTH:0]                  sum_ext;
  logic [ACC_WIDTH-1:0]                sum_sat;

  // Non-last terms are absorbed by the accumulator and never wait downstream.
  assign rdy2     = !v2 || !last2 || sum_ready;
  assign go2      = v2 && (!last2 || sum_ready);
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign prod_next = e1 * w1;

  // Saturating add of the current product to the running sum.
  always_comb begin
    acc_ext  = {acc[ACC_WIDTH-1], acc};
    prod_ext = {{(ACC_WIDTH + 1 - scstu_pkg::PROD_W){prod2[scstu_pkg::PROD_W-1]}}, prod2};
    sum_ext  = acc_ext + prod_ext;
    if (sum_ext[ACC_WIDTH] != sum_ext[ACC_WIDTH-1]) begin
      sum_sat = sum_ext[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[ACC_WIDTH-1:0];
    end
  end

  assign sum_valid = v2 && last2;
  assign sum       = sum_sat;
  assign sum_prior = prior2;
  assign sum_boost = boost2;

  // Stage valid bits and the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      acc <= '0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (go2) begin
        acc <= last2 ? '0 : sum_sat;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      e1     <= error_term;
      w1     <= weight;
      prior1 <= prior_state;
      boost1 <= unit_boost;
      last1  <= last_term;
    end
    if (v1 && rdy2) begin
      prod2  <= prod_next;
      prior2 <= prior1;
      boost2 <= boost1;
      last2  <= last1;
    end
  end

endmodule

// ----- rtl/core/scstu_update.sv -----
// Gain products, soft threshold, clamp and output register for one finished unit.
`timescale 1ns / 1ps

module scstu_update #(
  parameter int FRAC_BITS = scstu_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = scstu_pkg::ACC_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [scstu_pkg::GAIN_W-1:0]       step_size,
  input  logic [scstu_pkg::GAIN_W-1:0]       hidden_decay,
  input  logic                               sum_valid,
  output logic                               sum_ready,
  input  logic [ACC_WIDTH-1:0]               sum,
  input  logic [scstu_pkg::VAL_W-1:0]        sum_prior,
  input  logic [scstu_pkg::VAL_W-1:0]        sum_boost,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scstu_pkg::OUT_W-1:0]        new_state
);

  localparam int QSW = ACC_WIDTH - FRAC_BITS;
  localparam int QW  = (QSW > scstu_pkg::GRAD_CAP_W) ? QSW : scstu_pkg::GRAD_CAP_W;
  localparam int XW  = scstu_pkg::X_W;
  localparam int VW  = scstu_pkg::VAL_W;
  localparam int GW  = scstu_pkg::GAIN_W;

  // Sum stage.
  logic                 v3;
  logic [ACC_WIDTH-1:0] sum3;
  logic [VW-1:0]        prior3;
  logic [VW-1:0]        boost3;

  // Product stage.
  logic                               v4;
  logic [scstu_pkg::GRAD_CAP_W-1:0]   q_mag4;
  logic                               q_neg4;
  logic [VW:0]                        dp_mag4;
  logic [VW-1:0]                      prior4;
  logic [VW-1:0]                      th4;

  logic rdy4;
  logic rdy5;

  logic [ACC_WIDTH-1:0]             sum_mag;
  logic [ACC_WIDTH+GW-1:0]          q_full;
  logic [QW-1:0]                    q_wide;
  logic [scstu_pkg::GRAD_CAP_W-1:0] q_sat;
  logic [VW:0]                      prior_ext;
  logic [VW:0]                      prior_mag;
  logic [VW+GW:0]                   dp_full;
  logic [VW+GW-1:0]                 th_full;

  logic [XW-1:0]                    p_x;
  logic [XW-1:0]                    q_x;
  logic [XW-1:0]                    d_x;
  logic [XW-1:0]                    x;
  logic [XW-1:0]                    ax;
  logic [XW-1:0]                    m;
  logic [XW-1:0]                    one;
  logic [XW-1:0]                    mag;
  logic [XW-1:0]                    res;

  // Handshake between stages.
  assign rdy5      = !out_valid || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign sum_ready = !v3 || rdy4;

  // Magnitude products; each is truncated on its magnitude.
  always_comb begin
    sum_mag   = sum3[ACC_WIDTH-1] ? ('0 - sum3) : sum3;
    q_full    = (ACC_WIDTH+GW)'(sum_mag) * (ACC_WIDTH+GW)'(step_size);
    q_wide    = QW'(q_full[ACC_WIDTH+GW-1:FRAC_BITS+GW]);
    q_sat     = (q_wide > QW'(scstu_pkg::GRAD_CAP)) ? scstu_pkg::GRAD_CAP
                                                    : q_wide[scstu_pkg::GRAD_CAP_W-1:0];
    prior_ext = {prior3[VW-1], prior3};
    prior_mag = prior3[VW-1] ? ((VW+1)'(0) - prior_ext) : prior_ext;
    dp_full   = (VW+GW+1)'(prior_mag) * (VW+GW+1)'(hidden_decay);
    th_full   = (VW+GW)'(boost3) * (VW+GW)'(step_size);
  end

  // Update, shrink toward zero, clamp to one.
  always_comb begin
    p_x = {{(XW-VW){prior4[VW-1]}}, prior4};
    q_x = {{(XW-scstu_pkg::GRAD_CAP_W){1'b0}}, q_mag4};
    if (q_neg4) begin
      q_x = '0 - q_x;
    end
    d_x = {{(XW-VW-1){1'b0}}, dp_mag4};
    if (prior4[VW-1]) begin
      d_x = '0 - d_x;
    end
    x   = p_x + q_x - d_x;
    ax  = x[XW-1] ? ('0 - x) : x;
    m   = ax - {{(XW-VW){1'b0}}, th4};
    one = XW'(1) << FRAC_BITS;
    if (m[XW-1]) begin
      mag = '0;
    end else if (m > one) begin
      mag = one;
    end else begin
      mag = m;
    end
    res = (!x[XW-1] && (x != '0)) ? mag : ('0 - mag);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sum_ready) begin
        v3 <= sum_valid;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      if (rdy5) begin
        out_valid <= v4;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      sum3   <= sum;
      prior3 <= sum_prior;
      boost3 <= sum_boost;
    end
    if (v3 && rdy4) begin
      q_mag4  <= q_sat;
      q_neg4  <= sum3[ACC_WIDTH-1];
      dp_mag4 <= dp_full[VW+GW:GW];
      prior4  <= prior3;
      th4     <= th_full[VW+GW-1:GW];
    end
    if (v4 && rdy5) begin
      new_state <= res[scstu_pkg::OUT_W-1:0];
    end
  end

endmodule

// ----- rtl/core/sparse_code_soft_threshold_update.sv -----
// Top level of the soft-threshold state update for one sparse-coder hidden unit.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    error_term, weight, prior_state,
//                                              unit_boost, last_term
//   out      output     out_valid / out_ready  new_state
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One connection term is accepted per cycle while in_ready is high; the dot
// accumulator adds one product per cycle unless a stalled last term holds it.
// A result passes a five-stage pipeline (input, product, sum, gain products, output).
// Reset clears all stage valid bits and the accumulator, and loads the gain
// registers with their reset values.
// A stalled result holds the output register; earlier stages keep filling until
// a stage with no free slot is reached. A non-last term in the product stage never
// waits on the output side, but a stalled last term there holds back the terms
// behind it.
`timescale 1ns / 1ps

module sparse_code_soft_threshold_update #(
  parameter int FRAC_BITS = scstu_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH = scstu_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [scstu_pkg::VAL_W-1:0]    error_term,
  input  logic signed [scstu_pkg::VAL_W-1:0]    weight,
  input  logic signed [scstu_pkg::VAL_W-1:0]    prior_state,
  input  logic [scstu_pkg::VAL_W-1:0]           unit_boost,
  input  logic                                  last_term,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [scstu_pkg::OUT_W-1:0]    new_state,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scstu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [scstu_pkg::GAIN_W-1:0]          cfg_data
);

  logic [scstu_pkg::GAIN_W-1:0] step_size;
  logic [scstu_pkg::GAIN_W-1:0] hidden_decay;

  logic                         sum_valid;
  logic                         sum_ready;
  logic [ACC_WIDTH-1:0]         sum;
  logic [scstu_pkg::VAL_W-1:0]  sum_prior;
  logic [scstu_pkg::VAL_W-1:0]  sum_boost;
  logic [scstu_pkg::OUT_W-1:0]  new_state_raw;

  // Gain registers accept a write transaction in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= scstu_pkg::STEP_SIZE_RST;
      hidden_decay <= scstu_pkg::HIDDEN_DECAY_RST;
    end else if (cfg_valid) begin
      unique case (scstu_pkg::cfg_reg_t'(cfg_index))
        scstu_pkg::REG_STEP_SIZE:    step_size    <= cfg_data;
        scstu_pkg::REG_HIDDEN_DECAY: hidden_decay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Term products and dot accumulation.
  scstu_accum #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .error_term  (error_term),
    .weight      (weight),
    .prior_state (prior_state),
    .unit_boost  (unit_boost),
    .last_term   (last_term),
    .sum_valid   (sum_valid),
    .sum_ready   (sum_ready),
    .sum         (sum),
    .sum_prior   (sum_prior),
    .sum_boost   (sum_boost)
  );

  // Gradient step, decay, soft threshold and clamp.
  scstu_update #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_update (
    .clk          (clk),
    .rst          (rst),
    .step_size    (step_size),
    .hidden_decay (hidden_decay),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .sum          (sum),
    .sum_prior    (sum_prior),
    .sum_boost    (sum_boost),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .new_state    (new_state_raw)
  );

  assign new_state = signed'(new_state_raw);

endmodule
